// ===== design/rwps_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rwps_pkg
// Shared types and constants of the roulette wheel parent selector.
// ---------------------------------------------------------------------------
package rwps_pkg;

   localparam int MAX_MEMBERS  = 64;
   localparam int FIT_BITS     = 32;
   localparam int ROLL_BITS    = 32;
   localparam int MEMBER_BITS  = 6;
   localparam int STATUS_BITS  = 2;
   localparam int IDX_BITS     = $clog2(MAX_MEMBERS);
   localparam int CNT_BITS     = IDX_BITS + 1;
   localparam int CUM_BITS     = FIT_BITS + IDX_BITS + 2;
   localparam int MUL_LO_BITS  = 32;
   localparam int MUL_HI_BITS  = CUM_BITS - MUL_LO_BITS;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NO_WHEEL = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   typedef struct packed {
      logic                       cmd;
      logic signed [FIT_BITS-1:0] fitness;
      logic                       last;
      logic [ROLL_BITS-1:0]       roll;
   } req_type;

   typedef struct packed {
      logic [MEMBER_BITS-1:0] chosen_member;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic signed [FIT_BITS-1:0] fit;
      logic [IDX_BITS-1:0]        idx;
   } entry_type;

   typedef enum logic [2:0] {
      SR_ZERO,
      SR_K1,
      SR_K2,
      SR_I,
      SR_INEXT
   } sort_sel_type;

   typedef enum logic [1:0] {
      CR_ZERO,
      CR_LAST,
      CR_I,
      CR_INEXT
   } cum_sel_type;

   typedef struct packed {
      logic         latch_req;
      logic         clear_pop;
      logic         set_overflow;
      logic         k_load;
      logic         k_dec;
      logic         wr_shift;
      logic         wr_new;
      logic         cnt_inc;
      logic         set_ready;
      logic         i_clr;
      logic         i_inc;
      logic         run_clr;
      logic         lift_latch;
      logic         cum_wr;
      logic         first_latch;
      logic         diff_latch;
      logic         mul_lo;
      logic         mul_hi;
      logic         target_latch;
      logic         rsp_pick;
      logic         rsp_no_wheel;
      sort_sel_type sort_sel;
      cum_sel_type  cum_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic ready;
      logic cnt_full;
      logic last;
      logic is_draw;
      logic k_zero;
      logic k_one;
      logic shift_gt;
      logic i_last;
      logic cum_gt;
   } ctrl_stat_type;

endpackage
`default_nettype wire

// ===== design/roulette_wheel_parent_selector.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// roulette_wheel_parent_selector
// Fitness-proportionate parent selection over a sorted population.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A load keeps busy
// through a one-port walk through the sorted store, which moves each larger
// entry up one place; a load marked last then builds the wheel. A draw keeps
// busy through a linear scan of the cumulative store; its result appears on
// rsp_data with rsp_valid high for one cycle and must be taken then. A draw
// while no wheel is ready answers on the next cycle without waiting.
module roulette_wheel_parent_selector
   import rwps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   rwps_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rwps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== design/rwps_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rwps_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rwps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== design/rwps_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rwps_datapath
// Sorted population store, cumulative weight store, target arithmetic.
// ---------------------------------------------------------------------------
module rwps_datapath
   import rwps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_type       req_data,
   input  wire ctrl_cmd_type  cmd,
   output ctrl_stat_type      stat,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   req_type                    req_ff, req_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic                       ready_ff, ready_in;
   logic                       ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]        k_ff, k_in;
   logic [CNT_BITS-1:0]        i_ff, i_in;
   logic [CUM_BITS-1:0]        lift_ff, lift_in;
   logic [CUM_BITS-1:0]        run_ff, run_in;
   logic [CUM_BITS-1:0]        first_ff, first_in;
   logic [CUM_BITS-1:0]        diff_ff, diff_in;
   logic [ROLL_BITS+MUL_LO_BITS-1:0] plo_ff, plo_in;
   logic [ROLL_BITS+MUL_HI_BITS-1:0] phi_ff, phi_in;
   logic [CUM_BITS-1:0]        target_ff, target_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   entry_type                  sort_rd, sort_wr;
   logic [IDX_BITS-1:0]        sort_rd_addr;
   logic [CUM_BITS-1:0]        cum_rd;
   logic [IDX_BITS-1:0]        cum_rd_addr;
   logic [CNT_BITS-1:0]        k_m1, k_m2, i_p1, cnt_m1;
   logic [CUM_BITS-1:0]        fit_ext;

   assign k_m1   = k_ff - CNT_BITS'(1);
   assign k_m2   = k_ff - CNT_BITS'(2);
   assign i_p1   = i_ff + CNT_BITS'(1);
   assign cnt_m1 = cnt_ff - CNT_BITS'(1);
   assign fit_ext = {{(CUM_BITS-FIT_BITS){sort_rd.fit[FIT_BITS-1]}}, sort_rd.fit};

   always_comb begin
      unique case (cmd.sort_sel)
         SR_ZERO:  sort_rd_addr = '0;
         SR_K1:    sort_rd_addr = k_m1[IDX_BITS-1:0];
         SR_K2:    sort_rd_addr = k_m2[IDX_BITS-1:0];
         SR_I:     sort_rd_addr = i_ff[IDX_BITS-1:0];
         SR_INEXT: sort_rd_addr = i_p1[IDX_BITS-1:0];
         default:  sort_rd_addr = '0;
      endcase
      unique case (cmd.cum_sel)
         CR_ZERO:  cum_rd_addr = '0;
         CR_LAST:  cum_rd_addr = cnt_m1[IDX_BITS-1:0];
         CR_I:     cum_rd_addr = i_ff[IDX_BITS-1:0];
         CR_INEXT: cum_rd_addr = i_p1[IDX_BITS-1:0];
         default:  cum_rd_addr = '0;
      endcase
   end

   always_comb begin
      sort_wr.fit = req_ff.fitness;
      sort_wr.idx = cnt_ff[IDX_BITS-1:0];
      if (cmd.wr_shift) begin
         sort_wr = sort_rd;
      end
   end

   rwps_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_MEMBERS)) u_sort_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_shift | cmd.wr_new),
      .wr_addr (k_ff[IDX_BITS-1:0]),
      .wr_data (sort_wr),
      .rd_addr (sort_rd_addr),
      .rd_data (sort_rd)
   );

   rwps_ram #(.WIDTH(CUM_BITS), .DEPTH(MAX_MEMBERS)) u_cum_ram (
      .clock   (clock),
      .wr_en   (cmd.cum_wr),
      .wr_addr (i_ff[IDX_BITS-1:0]),
      .wr_data (run_in),
      .rd_addr (cum_rd_addr),
      .rd_data (cum_rd)
   );

   always_comb begin
      req_in    = cmd.latch_req ? req_data : req_ff;
      cnt_in    = cnt_ff;
      ready_in  = ready_ff;
      ovf_in    = ovf_ff;
      if (cmd.clear_pop) begin
         cnt_in   = '0;
         ready_in = 1'b0;
         ovf_in   = 1'b0;
      end
      if (cmd.set_overflow) begin
         ovf_in = 1'b1;
      end
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
      if (cmd.set_ready) begin
         ready_in = 1'b1;
      end
      k_in = k_ff;
      if (cmd.k_load) begin
         k_in = cnt_ff;
      end else if (cmd.k_dec) begin
         k_in = k_m1;
      end
      i_in = i_ff;
      if (cmd.i_clr) begin
         i_in = '0;
      end else if (cmd.i_inc) begin
         i_in = i_p1;
      end
      // A negative smallest fitness lifts every weight by its magnitude.
      lift_in  = cmd.lift_latch ? (sort_rd.fit[FIT_BITS-1] ? CUM_BITS'(0) - fit_ext : '0)
                                : lift_ff;
      run_in   = cmd.run_clr ? '0 : run_ff + fit_ext + lift_ff;
      first_in = cmd.first_latch ? cum_rd : first_ff;
      diff_in  = cmd.diff_latch ? cum_rd - first_ff : diff_ff;
      plo_in   = cmd.mul_lo ? req_ff.roll * diff_ff[MUL_LO_BITS-1:0] : plo_ff;
      phi_in   = cmd.mul_hi ? req_ff.roll * diff_ff[CUM_BITS-1:MUL_LO_BITS] : phi_ff;
      target_in = cmd.target_latch
                ? first_ff + CUM_BITS'(phi_ff)
                  + CUM_BITS'(plo_ff[ROLL_BITS+MUL_LO_BITS-1:ROLL_BITS])
                : target_ff;
      rsp_valid_in = cmd.rsp_pick | cmd.rsp_no_wheel;
      rsp_in       = rsp_ff;
      if (cmd.rsp_no_wheel) begin
         rsp_in.chosen_member = '0;
         rsp_in.status        = ST_NO_WHEEL;
      end else if (cmd.rsp_pick) begin
         rsp_in.chosen_member = MEMBER_BITS'(sort_rd.idx);
         rsp_in.status        = ovf_ff ? ST_OVERFLOW : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ready_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ready_ff     <= ready_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      k_ff      <= k_in;
      i_ff      <= i_in;
      lift_ff   <= lift_in;
      run_ff    <= cmd.lift_latch ? '0 : run_in;
      first_ff  <= first_in;
      diff_ff   <= diff_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
   end

   assign stat.ready    = ready_ff;
   assign stat.cnt_full = (cnt_ff == CNT_BITS'(MAX_MEMBERS));
   assign stat.last     = req_ff.last;
   assign stat.is_draw  = (req_data.cmd == CMD_DRAW);
   assign stat.k_zero   = (k_ff == '0);
   assign stat.k_one    = (k_ff == CNT_BITS'(1));
   assign stat.shift_gt = (sort_rd.fit > req_ff.fitness);
   assign stat.i_last   = (i_ff == cnt_m1);
   assign stat.cum_gt   = (cum_rd > target_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_MEMBERS))
      else $error("member count above capacity");
   a_ready_nonempty: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> cnt_ff != '0)
      else $error("wheel ready with empty population");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status == ST_OK || rsp_ff.status == ST_NO_WHEEL
                        || rsp_ff.status == ST_OVERFLOW))
      else $error("undefined status code");
`endif

endmodule
`default_nettype wire

// ===== design/rwps_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rwps_ctrl
// Sequencer for insertion, wheel build and draw.
// ---------------------------------------------------------------------------
module rwps_ctrl
   import rwps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire ctrl_stat_type stat,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [14:0] {
      S_IDLE    = 15'h0001,
      S_L_CHK   = 15'h0002,
      S_INS_RD  = 15'h0004,
      S_INS_CMP = 15'h0008,
      S_B_RD0   = 15'h0010,
      S_B_LIFT  = 15'h0020,
      S_B_SUM   = 15'h0040,
      S_D_FIRST = 15'h0080,
      S_D_TOTAL = 15'h0100,
      S_D_MULLO = 15'h0200,
      S_D_MULHI = 15'h0400,
      S_D_TGT   = 15'h0800,
      S_D_SCAN  = 15'h1000,
      S_D_IDX   = 15'h2000,
      S_SPARE   = 15'h4000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sort_sel = SR_ZERO;
      cmd.cum_sel  = CR_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               if (!stat.is_draw) begin
                  cmd.clear_pop = stat.ready;
                  state_in = S_L_CHK;
               end else if (!stat.ready) begin
                  cmd.rsp_no_wheel = 1'b1;
               end else begin
                  state_in = S_D_FIRST;
               end
            end
         end
         S_L_CHK: begin
            if (stat.cnt_full) begin
               cmd.set_overflow = 1'b1;
               state_in = stat.last ? S_B_RD0 : S_IDLE;
            end else begin
               cmd.k_load = 1'b1;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (stat.k_zero) begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in = stat.last ? S_B_RD0 : S_IDLE;
            end else begin
               cmd.sort_sel = SR_K1;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            // Larger entries move up one place; ties stay below the new item.
            if (stat.shift_gt) begin
               cmd.wr_shift = 1'b1;
               cmd.k_dec    = 1'b1;
               cmd.sort_sel = SR_K2;
               state_in = stat.k_one ? S_INS_RD : S_INS_CMP;
            end else begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in = stat.last ? S_B_RD0 : S_IDLE;
            end
         end
         S_B_RD0: begin
            cmd.i_clr = 1'b1;
            state_in  = S_B_LIFT;
         end
         S_B_LIFT: begin
            cmd.lift_latch = 1'b1;
            cmd.sort_sel   = SR_I;
            state_in = S_B_SUM;
         end
         S_B_SUM: begin
            cmd.cum_wr   = 1'b1;
            cmd.i_inc    = 1'b1;
            cmd.sort_sel = SR_INEXT;
            if (stat.i_last) begin
               cmd.set_ready = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_D_FIRST: begin
            cmd.first_latch = 1'b1;
            cmd.cum_sel     = CR_LAST;
            state_in = S_D_TOTAL;
         end
         S_D_TOTAL: begin
            cmd.diff_latch = 1'b1;
            state_in = S_D_MULLO;
         end
         S_D_MULLO: begin
            cmd.mul_lo = 1'b1;
            state_in = S_D_MULHI;
         end
         S_D_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in = S_D_TGT;
         end
         S_D_TGT: begin
            cmd.target_latch = 1'b1;
            cmd.i_clr        = 1'b1;
            state_in = S_D_SCAN;
         end
         S_D_SCAN: begin
            // The last entry is taken when no running sum exceeds the target.
            if (stat.cum_gt || stat.i_last) begin
               cmd.sort_sel = SR_I;
               state_in = S_D_IDX;
            end else begin
               cmd.i_inc   = 1'b1;
               cmd.cum_sel = CR_INEXT;
            end
         end
         S_D_IDX: begin
            cmd.rsp_pick = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");
   a_no_dual_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_shift && cmd.wr_new))
      else $error("two sorted-store writes in one cycle");
   a_pick_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_pick |-> $past(state_ff) == S_D_SCAN)
      else $error("result without a scan");
`endif

endmodule
`default_nettype wire

// ===== bench/roulette_wheel_parent_selector_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// roulette_wheel_parent_selector_checker
// Watches the command and result channels of the parent selector, keeps its
// own copy of the sorted population and wheel, predicts each draw's answer
// and compares every result against the oldest prediction.
// ---------------------------------------------------------------------------
module roulette_wheel_parent_selector_checker
   import rwps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_draws
);

   logic signed [FIT_BITS-1:0] pop_fitness [MAX_MEMBERS];
   logic [MEMBER_BITS-1:0]     pop_member  [MAX_MEMBERS];
   logic [63:0]                wheel_sum   [MAX_MEMBERS];
   int                         pop_size;
   logic                       wheel_built;
   logic                       dropped_loads;
   rsp_type                    expected_picks[$];

   function automatic void load_member(input logic signed [FIT_BITS-1:0] f);
      int slot;
      if (pop_size >= MAX_MEMBERS) begin
         dropped_loads = 1'b1;
         return;
      end
      slot = 0;
      while (slot < pop_size && pop_fitness[slot] <= f) slot++;
      for (int k = pop_size; k > slot; k--) begin
         pop_fitness[k] = pop_fitness[k-1];
         pop_member[k]  = pop_member[k-1];
      end
      pop_fitness[slot] = f;
      pop_member[slot]  = MEMBER_BITS'(pop_size);
      pop_size++;
   endfunction

   function automatic void build_wheel();
      logic [63:0] running;
      logic [63:0] lift;
      running = '0;
      lift = (pop_fitness[0] < 0) ? 64'(-64'(signed'(pop_fitness[0]))) : '0;
      for (int i = 0; i < pop_size; i++) begin
         running = running + 64'(signed'(pop_fitness[i])) + lift;
         wheel_sum[i] = running;
      end
      wheel_built = 1'b1;
   endfunction

   function automatic rsp_type spin_wheel(input logic [ROLL_BITS-1:0] roll);
      rsp_type     pick;
      logic [63:0] target;
      logic [95:0] product;
      int          slot;
      if (!wheel_built || pop_size == 0) begin
         pick.chosen_member = '0;
         pick.status        = ST_NO_WHEEL;
         return pick;
      end
      product = 96'(roll) * 96'(wheel_sum[pop_size-1] - wheel_sum[0]);
      target  = wheel_sum[0] + 64'(product >> ROLL_BITS);
      slot = pop_size - 1;
      for (int i = 0; i < pop_size; i++) begin
         if (wheel_sum[i] > target) begin
            slot = i;
            break;
         end
      end
      pick.chosen_member = pop_member[slot];
      pick.status        = dropped_loads ? ST_OVERFLOW : ST_OK;
      return pick;
   endfunction

   assign pending_draws = expected_picks.size();

   always @(posedge clock) begin
      rsp_type want;
      rsp_type guess;
      int      errs;
      errs = 0;
      if (reset) begin
         pop_size      = 0;
         wheel_built   = 1'b0;
         dropped_loads = 1'b0;
         expected_picks.delete();
         fail_count   <= 0;
      end else begin
         if (start && !busy) begin
            if (req_data.cmd == CMD_LOAD) begin
               if (wheel_built) begin
                  pop_size      = 0;
                  wheel_built   = 1'b0;
                  dropped_loads = 1'b0;
               end
               load_member(req_data.fitness);
               if (req_data.last && pop_size > 0) build_wheel();
            end else begin
               guess = spin_wheel(req_data.roll);
               expected_picks.insert(expected_picks.size(), guess);
            end
         end
         if (rsp_valid) begin
            if (expected_picks.size() == 0) begin
               $error("unexpected result: chosen_member %0d status %0d",
                      rsp_data.chosen_member, rsp_data.status);
               errs++;
            end else begin
               want = expected_picks.pop_front();
               if (want.chosen_member !== rsp_data.chosen_member) begin
                  $error("chosen_member: expected %0d, actual %0d",
                         want.chosen_member, rsp_data.chosen_member);
                  errs++;
               end
               if (want.status !== rsp_data.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_data.status);
                  errs++;
               end
            end
         end
         if (errs != 0) begin
            fail_count <= fail_count + errs;
         end
      end
   end

endmodule

// ===== bench/roulette_wheel_parent_selector_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// roulette_wheel_parent_selector_test
// Drives populations of loads and random draws into the parent selector
// with varying sender idling; the checker predicts and compares results.
// ---------------------------------------------------------------------------
module roulette_wheel_parent_selector_test;
   import rwps_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_draws;
   int      idle_percent;
   int      cycle_count = 0;

   roulette_wheel_parent_selector i_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data
   );

   roulette_wheel_parent_selector_checker i_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .fail_count, .pending_draws
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("roulette_wheel_parent_selector regression: fail");
         $finish;
      end
   end

   // Presents one item and holds it until the block takes it. Start stays
   // high into the next item unless the sender idles first.
   task automatic send_item(input logic cmd, input logic [31:0] fit,
                            input logic last, input logic [31:0] roll);
      if ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_percent) @(posedge clock);
      end
      start            <= 1'b1;
      req_data.cmd     <= cmd;
      req_data.fitness <= fit;
      req_data.last    <= last;
      req_data.roll    <= roll;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_fitness();
      case ($urandom_range(5))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'($urandom_range(7)) - 32'd3;
         3:       return 32'($urandom_range(2000)) - 32'd1000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_roll();
      case ($urandom_range(5))
         0:       return 32'h0;
         1:       return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_population(input int size);
      for (int i = 0; i < size; i++)
         send_item(CMD_LOAD, pick_fitness(), i == size - 1, $urandom());
   endtask

   initial begin
      int sent;
      int size;
      idle_percent = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: draw with no wheel, one member, extremes, ties, all zero.
      send_item(CMD_DRAW, 32'h0, 1'b0, 32'hffff_ffff);
      send_item(CMD_LOAD, 32'h7fff_ffff, 1'b1, 32'h0);
      send_item(CMD_DRAW, 32'h0, 1'b0, 32'h0);
      send_item(CMD_LOAD, 32'h8000_0000, 1'b0, 32'h0);
      send_item(CMD_LOAD, 32'h7fff_ffff, 1'b0, 32'h0);
      send_item(CMD_LOAD, 32'h0000_0005, 1'b0, 32'h0);
      send_item(CMD_LOAD, 32'h0000_0005, 1'b1, 32'h0);
      send_item(CMD_DRAW, 32'h0, 1'b0, 32'h0);
      send_item(CMD_DRAW, 32'h0, 1'b0, 32'hffff_ffff);
      send_item(CMD_DRAW, 32'h0, 1'b0, 32'h8000_0000);
      for (int i = 0; i < 4; i++) send_item(CMD_LOAD, 32'h0, i == 3, 32'h0);
      send_item(CMD_DRAW, 32'h0, 1'b0, 32'h1234_5678);
      // Overflow: more loads than the store holds, the last three dropped.
      for (int i = 0; i < MAX_MEMBERS + 3; i++)
         send_item(CMD_LOAD, pick_fitness(), i == MAX_MEMBERS + 2, 32'h0);
      send_item(CMD_DRAW, 32'h0, 1'b0, 32'hffff_ffff);
      send_item(CMD_DRAW, 32'h0, 1'b0, 32'h0);

      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: idle_percent = 0;
            1: idle_percent = 46;
            2: idle_percent = 7;
            default: idle_percent = 0;
         endcase
         while (sent < (phase + 1) * 190) begin
            // Mostly small populations, a few near-full, full or overfull ones.
            size = ($urandom_range(19) == 0) ? $urandom_range(60, 67)
                                             : $urandom_range(1, 8);
            send_population(size);
            sent += size;
            for (int d = $urandom_range(1, 10); d > 0; d--) begin
               send_item(CMD_DRAW, $urandom(), 1'($urandom()), pick_roll());
               sent++;
            end
            if ($urandom_range(9) == 0) begin
               // A load not marked last leaves no wheel until the next one.
               send_item(CMD_LOAD, pick_fitness(), 1'b0, $urandom());
               send_item(CMD_DRAW, $urandom(), 1'b0, pick_roll());
               sent += 2;
            end
         end
      end
      start <= 1'b0;

      while (pending_draws != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("roulette_wheel_parent_selector regression: pass");
      end else begin
         $display("roulette_wheel_parent_selector regression: fail");
      end
      $finish;
   end

endmodule
